// ===== rtl/core/wbss_pkg.sv =====
// ----------------------------------------------------------------------------
// wbss_pkg: shared types and constants for the wildcard signature scanner
// Register map, status codes, configuration bundle and default parameters.
// ----------------------------------------------------------------------------
package wbss_pkg;

	// signature storage is fixed at sixteen bytes
	localparam int SIG_BYTES = 16;
	localparam int SIG_BITS  = SIG_BYTES * 8;
	localparam int LEN_W     = 5;
	localparam int CARE_W    = 16;
	localparam int ADDR_W    = 64;
	localparam int TALLY_W   = 8;

	// default parameter values
	localparam int DEF_MAX_PATTERN = 16;
	localparam int DEF_OFFSET_BITS = 32;

	// configuration port
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	// register index, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_PAT_LO = 3'd0,
		REG_PAT_HI = 3'd1,
		REG_CARE   = 3'd2,
		REG_LEN    = 3'd3,
		REG_BASE   = 3'd4
	} reg_idx_t;

	// result status
	typedef enum logic [1:0] {
		ST_NOT_FOUND = 2'd0,
		ST_UNIQUE    = 2'd1,
		ST_AMBIGUOUS = 2'd2
	} scan_status_t;

	// output tdata layout
	localparam int OUT_DATA_W = 80;

	// configuration bundle from the register block
	typedef struct packed {
		logic [SIG_BITS-1:0] pattern;
		logic [CARE_W-1:0]   care;
		logic [LEN_W-1:0]    len;
		logic [ADDR_W-1:0]   base;
	} cfg_t;

endpackage

// ===== rtl/core/wbss_regs.sv =====
// ----------------------------------------------------------------------------
// wbss_regs: configuration register block
// APB-style write/read access to the signature, care mask, length and base.
// ----------------------------------------------------------------------------
module wbss_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wbss_pkg::PADDR_W-1:0]    paddr,
	input  logic [wbss_pkg::PDATA_W-1:0]    pwdata,
	output logic [wbss_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	output wbss_pkg::cfg_t                  cfg
);
	import wbss_pkg::*;

	logic [SIG_BITS/2-1:0] pat_lo_q;
	logic [SIG_BITS/2-1:0] pat_hi_q;
	logic [CARE_W-1:0]     care_q;
	logic [LEN_W-1:0]      len_q;
	logic [ADDR_W-1:0]     base_q;
	logic                  wr_en;
	reg_idx_t              idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel & penable & pwrite & pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			len_q    <= '0;
			base_q   <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_PAT_LO: pat_lo_q <= pwdata;
				REG_PAT_HI: pat_hi_q <= pwdata;
				REG_CARE:   care_q   <= pwdata[CARE_W-1:0];
				REG_LEN:    len_q    <= pwdata[LEN_W-1:0];
				REG_BASE:   base_q   <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_PAT_LO: prdata = pat_lo_q;
			REG_PAT_HI: prdata = pat_hi_q;
			REG_CARE:   prdata = PDATA_W'(care_q);
			REG_LEN:    prdata = PDATA_W'(len_q);
			REG_BASE:   prdata = base_q;
			default:    prdata = '0;
		endcase
	end

	assign cfg.pattern = {pat_hi_q, pat_lo_q};
	assign cfg.care    = care_q;
	assign cfg.len     = len_q;
	assign cfg.base    = base_q;

endmodule

// ===== rtl/core/wbss_cell.sv =====
// ----------------------------------------------------------------------------
// wbss_cell: one window byte of the scan chain
// Holds an image byte, passes it to the next cell on each transfer and checks
// it against the signature byte that lines up with its place in the window.
// ----------------------------------------------------------------------------
module wbss_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  logic                              shift_en,
	input  logic [7:0]                        byte_in,
	input  logic [wbss_pkg::SIG_BITS-1:0]     pattern,
	input  logic [wbss_pkg::CARE_W-1:0]       care,
	input  logic [wbss_pkg::LEN_W-1:0]        len,
	output logic [7:0]                        byte_out,
	output logic                              ok
);
	import wbss_pkg::*;

	localparam logic [6:0] IDX_W = 7'(IDX);

	logic [7:0] byte_q;
	logic [6:0] k_full;
	logic [3:0] k;
	logic       in_window;

	// window byte, newest at cell zero
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	// cell j faces signature byte len-1-j
	always_comb begin
		k_full    = 7'(len) - 7'd1 - IDX_W;
		k         = k_full[3:0];
		in_window = 7'(len) > IDX_W;
		ok        = !in_window || !care[k] || (byte_q == pattern[k*8 +: 8]);
	end

	assign byte_out = byte_q;

endmodule

// ===== rtl/core/wildcard_byte_signature_scan.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan: masked byte signature search over an image
// Chain of window cells, a compare/tally stage and a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   The image streams in on the s_ group, one byte per transfer in s_tdata,
//   with s_tlast on its final byte. One result per image leaves on the m_
//   group: status, match address (base plus offset when unique) and count.
//   Signature, care mask, length and image base are set through the APB
//   port while the block is idle; registers sit at 8-byte strides.
//   Throughput is one byte per cycle while s_tready is high: the window
//   shifts through the cell chain at each transfer and all cells compare
//   in parallel the next cycle. The last byte's transfer loads the window
//   register, and the result register then loads and raises m_tvalid once
//   a waiting result has been taken.
//   If the receiver stalls while a result waits and another image ends,
//   s_tready drops until the waiting result is taken; other bytes keep
//   flowing. Reset clears the configuration registers, the counters and
//   the valid flags; scan state also clears after every image.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan #(
	parameter int MAX_PATTERN = wbss_pkg::DEF_MAX_PATTERN,
	parameter int OFFSET_BITS = wbss_pkg::DEF_OFFSET_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// image byte stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] image_byte
	input  logic                              s_tlast,   // last_byte
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] scan_status, [65:2] match_address, [73:66] match_count, rest zero
	output logic [wbss_pkg::OUT_DATA_W-1:0]   m_tdata,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wbss_pkg::PADDR_W-1:0]      paddr,
	input  logic [wbss_pkg::PDATA_W-1:0]      pwdata,
	output logic [wbss_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	import wbss_pkg::*;

	localparam int LEN_LIMIT = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;

	cfg_t                    cfg;
	logic [7:0]              chain [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]  cell_ok;
	logic                    xfer_in;
	logic                    stall;

	logic [OFFSET_BITS-1:0]  seen_q;
	logic [OFFSET_BITS-1:0]  seen_next;
	logic [OFFSET_BITS-1:0]  seen_s1;
	logic                    valid_s1;
	logic                    last_s1;

	logic [TALLY_W-1:0]      tally_q;
	logic [OFFSET_BITS-1:0]  first_q;
	logic [TALLY_W-1:0]      tally_next;
	logic [OFFSET_BITS-1:0]  first_next;
	logic                    len_ok;
	logic                    hit;
	logic                    done;

	logic                    out_valid_q;
	scan_status_t            status_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [TALLY_W-1:0]      count_q;
	scan_status_t            status_d;
	logic [ADDR_W-1:0]       addr_d;

	// configuration registers
	wbss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// flow control: a finished image waits only on a full, stalled output
	assign stall    = valid_s1 & last_s1 & out_valid_q & ~m_tready;
	assign s_tready = ~stall;
	assign xfer_in  = s_tvalid & s_tready;

	// window chain
	genvar j;
	generate
		for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
			logic [7:0] cell_in;
			if (j == 0) begin : g_head
				assign cell_in = s_tdata;
			end else begin : g_link
				assign cell_in = chain[j-1];
			end
			wbss_cell #(
				.IDX (j)
			) u_cell (
				.clk      (clk),
				.shift_en (xfer_in),
				.byte_in  (cell_in),
				.pattern  (cfg.pattern),
				.care     (cfg.care),
				.len      (cfg.len),
				.byte_out (chain[j]),
				.ok       (cell_ok[j])
			);
		end
	endgenerate

	// saturating byte count
	assign seen_next = (&seen_q) ? seen_q : seen_q + OFFSET_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			if (s_tvalid) begin
				seen_q  <= s_tlast ? '0 : seen_next;
				last_s1 <= s_tlast;
			end
		end
	end

	// count that goes with the byte in the window stage
	always_ff @(posedge clk) begin
		if (xfer_in) begin
			seen_s1 <= seen_next;
		end
	end

	// window compare and tally update
	always_comb begin
		len_ok     = (cfg.len != '0) && (cfg.len <= LEN_W'(LEN_LIMIT));
		hit        = len_ok && (seen_s1 >= OFFSET_BITS'(cfg.len)) && (&cell_ok);
		tally_next = tally_q;
		first_next = first_q;
		if (hit) begin
			if (tally_q == '0) begin
				first_next = seen_s1 - OFFSET_BITS'(cfg.len);
			end
			if (tally_q != '1) begin
				tally_next = tally_q + TALLY_W'(1);
			end
		end
		done = valid_s1 & last_s1 & ~stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
			first_q <= '0;
		end else if (valid_s1 && !stall) begin
			tally_q <= last_s1 ? '0 : tally_next;
			first_q <= last_s1 ? '0 : first_next;
		end
	end

	// result decode
	always_comb begin
		if (tally_next == '0) begin
			status_d = ST_NOT_FOUND;
			addr_d   = '0;
		end else if (tally_next == TALLY_W'(1)) begin
			status_d = ST_UNIQUE;
			addr_d   = cfg.base + ADDR_W'(first_next);
		end else begin
			status_d = ST_AMBIGUOUS;
			addr_d   = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= status_d;
			addr_q   <= addr_d;
			count_q  <= tally_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - TALLY_W - ADDR_W - 2){1'b0}}, count_q, addr_q, status_q};

endmodule
